### rtl/kqvlp_pkg.sv
// Package: shared codes, command/status structs and byte classes for the line parser.
`default_nettype none
package kqvlp_pkg;

    localparam int HOLD_DEPTH = 16;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [1:0] K_KEY = 2'd0;
    localparam logic [1:0] K_VAL = 2'd1;
    localparam logic [1:0] K_ACC = 2'd2;
    localparam logic [1:0] K_REJ = 2'd3;

    // source of the emitted byte
    localparam logic [2:0] SRC_IN    = 3'd0;
    localparam logic [2:0] SRC_HELD  = 3'd1;
    localparam logic [2:0] SRC_BSL   = 3'd2;
    localparam logic [2:0] SRC_ZERO  = 3'd3;
    localparam logic [2:0] SRC_SAVED = 3'd4;

    typedef struct packed {
        logic       out_load;
        logic [1:0] out_kind;
        logic [2:0] out_sel;
        logic       out_last;
        logic       hold_push;
        logic       hold_clear;
        logic       save_byte;
        logic       idx_inc;
    } t_cmd;

    typedef struct packed {
        logic is_ws;
        logic is_digit;
        logic is_colon;
        logic is_hash;
        logic is_quote;
        logic is_bslash;
        logic cnt_zero;
        logic cnt_full;
        logic idx_lt_cnt;
        logic out_free;
    } t_status;

    function automatic logic f_is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage
`default_nettype wire

### rtl/kqvlp_dpath.sv
// Datapath: byte classes, held whitespace store, saved byte and output register.
`default_nettype none
module kqvlp_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [7:0]        i_text_byte,
    input  wire logic              i_out_ready,
    input  wire kqvlp_pkg::t_cmd   i_cmd,
    output kqvlp_pkg::t_status     o_status,
    output logic                   o_out_valid,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_out_byte,
    output logic                   o_last
);
    import kqvlp_pkg::*;

    logic [7:0]       r_held [HOLD_DEPTH];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [7:0]       r_saved;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_out_byte;
    logic             r_last;
    logic [7:0]       n_sel_byte;
    logic [7:0]       held_rd;

    assign held_rd = r_held[r_idx[IDX_W-1:0]];

    always_comb begin
        o_status.is_ws      = f_is_ws(i_text_byte);
        o_status.is_digit   = f_is_digit(i_text_byte);
        o_status.is_colon   = (i_text_byte == CH_COLON);
        o_status.is_hash    = (i_text_byte == CH_HASH);
        o_status.is_quote   = (i_text_byte == CH_QUOTE);
        o_status.is_bslash  = (i_text_byte == CH_BSLASH);
        o_status.cnt_zero   = (r_cnt == '0);
        o_status.cnt_full   = (r_cnt == CNT_W'(HOLD_DEPTH));
        o_status.idx_lt_cnt = (r_idx < r_cnt);
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        case (i_cmd.out_sel)
            SRC_IN:    n_sel_byte = i_text_byte;
            SRC_HELD:  n_sel_byte = held_rd;
            SRC_BSL:   n_sel_byte = CH_BSLASH;
            SRC_SAVED: n_sel_byte = r_saved;
            default:   n_sel_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (i_cmd.hold_clear) begin
            n_cnt = '0;
            n_idx = '0;
        end else begin
            if (i_cmd.hold_push) n_cnt = r_cnt + CNT_W'(1);
            if (i_cmd.idx_inc)   n_idx = r_idx + CNT_W'(1);
        end
        if (i_cmd.out_load)     n_out_valid = 1'b1;
        else if (i_out_ready)   n_out_valid = 1'b0;
        else                    n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_push) r_held[r_cnt[IDX_W-1:0]] <= i_text_byte;
        if (i_cmd.save_byte) r_saved <= i_text_byte;
        if (i_cmd.out_load) begin
            r_kind     <= i_cmd.out_kind;
            r_out_byte <= n_sel_byte;
            r_last     <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

endmodule
`default_nettype wire

### rtl/kqvlp_ctrl.sv
// Controller: parse mode and emit-phase state machine.
`default_nettype none
module kqvlp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_op,
    input  wire kqvlp_pkg::t_status  i_status,
    output logic                     o_in_ready,
    output kqvlp_pkg::t_cmd          o_cmd
);
    import kqvlp_pkg::*;

    localparam logic [3:0] M_LEAD   = 4'd0;
    localparam logic [3:0] M_KEY    = 4'd1;
    localparam logic [3:0] M_PRE    = 4'd2;
    localparam logic [3:0] M_DIGITS = 4'd3;
    localparam logic [3:0] M_POST   = 4'd4;
    localparam logic [3:0] M_VALUE  = 4'd5;
    localparam logic [3:0] M_ESC    = 4'd6;
    localparam logic [3:0] M_BAD    = 4'd7;
    localparam logic [3:0] M_IGNORE = 4'd8;

    localparam logic [1:0] PH_RUN   = 2'd0;
    localparam logic [1:0] PH_FLUSH = 2'd1;
    localparam logic [1:0] PH_ESC2  = 2'd2;

    logic [3:0] r_mode, n_mode;
    logic [1:0] r_phase, n_phase;
    logic       accept;

    assign o_in_ready = (r_phase == PH_RUN) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_phase)
            PH_RUN: begin
                if (accept) begin
                    if (i_op == OP_EOL) begin
                        if (r_mode inside {[M_KEY:M_BAD]}) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_kind = K_REJ;
                            o_cmd.out_sel  = SRC_ZERO;
                            o_cmd.out_last = 1'b1;
                        end
                        o_cmd.hold_clear = 1'b1;
                        n_mode = M_LEAD;
                    end else begin
                        case (r_mode)
                            M_LEAD: begin
                                if (i_status.is_ws) begin
                                    n_mode = M_LEAD;
                                end else if (i_status.is_hash || i_status.is_colon) begin
                                    n_mode = M_IGNORE;
                                end else begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.out_kind = K_KEY;
                                    o_cmd.out_sel  = SRC_IN;
                                    o_cmd.out_last = 1'b1;
                                    n_mode = M_KEY;
                                end
                            end
                            M_KEY: begin
                                if (i_status.is_colon) begin
                                    o_cmd.hold_clear = 1'b1;
                                    n_mode = M_PRE;
                                end else if (i_status.is_ws) begin
                                    o_cmd.hold_push = !i_status.cnt_full;
                                end else if (i_status.cnt_zero) begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.out_kind = K_KEY;
                                    o_cmd.out_sel  = SRC_IN;
                                    o_cmd.out_last = 1'b1;
                                end else begin
                                    // first held byte now, the rest in the flush phase
                                    o_cmd.out_load  = 1'b1;
                                    o_cmd.out_kind  = K_KEY;
                                    o_cmd.out_sel   = SRC_HELD;
                                    o_cmd.save_byte = 1'b1;
                                    o_cmd.idx_inc   = 1'b1;
                                    n_phase = PH_FLUSH;
                                end
                            end
                            M_PRE, M_DIGITS, M_POST: begin
                                if (i_status.is_quote) begin
                                    n_mode = M_VALUE;
                                end else if (i_status.is_ws) begin
                                    if (r_mode == M_DIGITS) n_mode = M_POST;
                                end else if (i_status.is_digit && r_mode != M_POST) begin
                                    n_mode = M_DIGITS;
                                end else begin
                                    n_mode = M_BAD;
                                end
                            end
                            M_VALUE: begin
                                if (i_status.is_bslash) begin
                                    n_mode = M_ESC;
                                end else if (i_status.is_quote) begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.out_kind = K_ACC;
                                    o_cmd.out_sel  = SRC_ZERO;
                                    o_cmd.out_last = 1'b1;
                                    n_mode = M_IGNORE;
                                end else begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.out_kind = K_VAL;
                                    o_cmd.out_sel  = SRC_IN;
                                    o_cmd.out_last = 1'b1;
                                end
                            end
                            M_ESC: begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_kind = K_VAL;
                                if (i_status.is_quote || i_status.is_bslash) begin
                                    o_cmd.out_sel  = SRC_IN;
                                    o_cmd.out_last = 1'b1;
                                end else begin
                                    // unknown escape: backslash, then the byte itself
                                    o_cmd.out_sel   = SRC_BSL;
                                    o_cmd.save_byte = 1'b1;
                                    n_phase = PH_ESC2;
                                end
                                n_mode = M_VALUE;
                            end
                            M_BAD, M_IGNORE: begin
                                n_mode = r_mode;
                            end
                            default: begin
                                n_mode = M_IGNORE;
                            end
                        endcase
                    end
                end
            end
            PH_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = K_KEY;
                    if (i_status.idx_lt_cnt) begin
                        o_cmd.out_sel = SRC_HELD;
                        o_cmd.idx_inc = 1'b1;
                    end else begin
                        o_cmd.out_sel    = SRC_SAVED;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.hold_clear = 1'b1;
                        n_phase = PH_RUN;
                    end
                end
            end
            PH_ESC2: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = K_VAL;
                    o_cmd.out_sel  = SRC_SAVED;
                    o_cmd.out_last = 1'b1;
                    n_phase = PH_RUN;
                end
            end
            default: begin
                n_phase = PH_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_LEAD;
            r_phase <= PH_RUN;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
        end
    end

endmodule
`default_nettype wire

### rtl/key_quoted_value_line_parser_core.sv
// Top level: key: [digits] "value" line parser, controller plus datapath.
//
// Input channel (i_in_valid / o_in_ready): one beat is either a text byte (i_op = 0)
// or an end of line (i_op = 1, i_text_byte ignored).
// Output channel (o_out_valid / i_out_ready): one beat per result: key byte, value
// byte, accept marker or reject marker; o_last flags the final result of an input.
// Results are registered: each one is held in the output register until it is taken.
// Throughput: one input beat per cycle while the output side keeps up. An input
// that yields more than one result holds the input side until its last result is loaded:
// a key byte that releases n held whitespace bytes emits those and then itself, and an
// unknown escape emits a backslash and then the byte. The output register is the only buffer;
// the next beat can be taken in the same cycle that the waiting result is taken.
// Stall: while a result waits, input is held off and all state is frozen.
// Reset (synchronous, active low): parse returns to line start, held count clears,
// output goes empty. No clearing pass; the held store needs none.
`default_nettype none
module key_quoted_value_line_parser_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_op,
    input  wire logic [7:0] i_text_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);
    import kqvlp_pkg::*;

    t_cmd    cmd;
    t_status status;

    kqvlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    kqvlp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_byte (i_text_byte),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    a_ready_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("input ready while output slot is occupied");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == K_ACC || o_kind == K_REJ)) |-> o_last)
        else $error("accept/reject marker not flagged last");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == K_ACC || o_kind == K_REJ)) |-> (o_out_byte == 8'h00))
        else $error("marker carries nonzero byte");

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

endmodule
`default_nettype wire
